// ===== hw/rtl/lmsf_pkg.sv =====
// Shared constants for the LMS adaptive FIR unit: command and register codes,
// fixed field widths and the operand sizes of the shared multiplier.
// No dependencies.
`default_nettype none

package lmsf_pkg;

  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int TAPCNT_W   = 6;
  localparam int WIDX_W     = 5;
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 32;
  localparam int STEP_W     = 32;

  // Shared multiplier: signed 33 x 17 covers weight x sample and the
  // unsigned step x 16-bit digit products. Every product fits in 49 bits.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = 49;
  localparam int DIG_W   = 16;

  localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT     = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;

endpackage

`default_nettype wire

// ===== hw/rtl/lmsf_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
// Used for the weight and history banks; no dependencies.
`default_nettype none

module lmsf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lms_adaptive_fir_unit.sv =====
// LMS adaptive FIR unit, top level; depends on lmsf_pkg and lmsf_ram.
// A filter request steps each active tap through read, error product, weight update
// and tap product on one shared multiplier: in_ready returns as out_valid rises with
// adaptation off, or once the error factor is updated with it on. Load requests
// complete in idle, and clear requests zero one channel's history. After reset a
// clearing pass over every entry zeroes both banks before the first request.
`default_nettype none

module lms_adaptive_fir_unit #(
  parameter int TAPS             = 32,
  parameter int CHANNELS         = 2,
  parameter int WEIGHT_FRAC_BITS = 16,
  parameter int STEP_FRAC_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration write port
  input  logic                                  cfg_write_en,
  input  logic [lmsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lmsf_pkg::CFG_DATA_W-1:0]       cfg_data,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [lmsf_pkg::CMD_W-1:0]            in_command,
  input  logic                                  in_channel,
  input  logic signed [lmsf_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic signed [lmsf_pkg::SAMPLE_W-1:0]  in_reference,
  input  logic [lmsf_pkg::WIDX_W-1:0]           in_weight_index,
  input  logic signed [lmsf_pkg::WEIGHT_W-1:0]  in_weight_value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lmsf_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                  out_channel,
  output logic                                  out_saturated
);

  import lmsf_pkg::*;

  // Geometry. Each channel owns TAPS consecutive entries of both banks.
  localparam int DEPTH   = CHANNELS * TAPS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TI_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int TC_W    = $clog2(TAPS + 1);
  // The accumulator holds the exact sum of up to TAPS products.
  localparam int ACC_W   = 48 + $clog2(TAPS) + 1;
  localparam int E_W     = ACC_W + 1;
  localparam int NDIG    = (E_W + DIG_W - 1) / DIG_W;
  localparam int MAG_W   = NDIG * DIG_W;
  localparam int SUM_W   = MAG_W + STEP_W;
  localparam int CNT_MAX = (DEPTH > NDIG) ? DEPTH : NDIG;
  localparam int CW      = $clog2(CNT_MAX + 1);

  // Output clamp limits in accumulator units (2^-WEIGHT_FRAC_BITS of a sample).
  localparam logic signed [ACC_W-1:0] OUT_HI =
    {{(ACC_W - SAMPLE_W - WEIGHT_FRAC_BITS){1'b0}}, S16_MAX, {WEIGHT_FRAC_BITS{1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_LO =
    {{(ACC_W - SAMPLE_W - WEIGHT_FRAC_BITS){1'b1}}, S16_MIN, {WEIGHT_FRAC_BITS{1'b0}}};

  // Rounding constant and magnitude limits for the error factor.
  localparam logic [SUM_W:0] RND_HALF = (SUM_W + 1)'(1) << (STEP_FRAC_BITS - 1);
  localparam logic [SUM_W:0] LIM_POS  = (SUM_W + 1)'(32'h7fff_ffff);
  localparam logic [SUM_W:0] LIM_NEG  = (SUM_W + 1)'(32'h8000_0000);

  // Sequencer states.
  localparam logic [3:0] ST_INIT = 4'd0;   // clearing pass after reset
  localparam logic [3:0] ST_IDLE = 4'd1;   // ready for a request
  localparam logic [3:0] ST_CLR  = 4'd2;   // zeroing one channel's history
  localparam logic [3:0] ST_RD   = 4'd3;   // tap: present addresses, fold product
  localparam logic [3:0] ST_MW   = 4'd4;   // tap: error factor x older sample
  localparam logic [3:0] ST_UP   = 4'd5;   // tap: weight update and write back
  localparam logic [3:0] ST_MX   = 4'd6;   // tap: sample x updated weight
  localparam logic [3:0] ST_FIN  = 4'd7;   // last product, history push
  localparam logic [3:0] ST_OUT  = 4'd8;   // load the output register
  localparam logic [3:0] ST_ESUB = 4'd9;   // error = reference - sum
  localparam logic [3:0] ST_EABS = 4'd10;  // error magnitude and sign
  localparam logic [3:0] ST_EMUL = 4'd11;  // step x magnitude, one digit a cycle
  localparam logic [3:0] ST_RND  = 4'd12;  // add the rounding half
  localparam logic [3:0] ST_ESAT = 4'd13;  // scale, saturate, apply sign

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are only expected while the unit is idle.
  // ---------------------------------------------------------------------------
  logic [TAPCNT_W-1:0] tap_count_r;
  logic [STEP_W-1:0]   step_r;
  logic                adapt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPCNT_W'(1);
      step_r      <= '0;
      adapt_r     <= 1'b1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_TAP_COUNT: tap_count_r <= cfg_data[TAPCNT_W-1:0];
        CFG_STEP_SIZE: step_r      <= cfg_data[STEP_W-1:0];
        CFG_ADAPT:     adapt_r     <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // A tap count of zero behaves as one, and anything above TAPS as TAPS.
  logic [TC_W-1:0] eff_taps;

  always_comb begin
    if (tap_count_r == '0) begin
      eff_taps = TC_W'(1);
    end else if (32'(tap_count_r) > 32'(TAPS)) begin
      eff_taps = TC_W'(TAPS);
    end else begin
      eff_taps = TC_W'(tap_count_r);
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [3:0]                 state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       ch_r, ch_nxt;
  logic [AW-1:0]              base_r, base_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [SAMPLE_W-1:0] ref_r, ref_nxt;
  logic signed [SAMPLE_W-1:0] cur_r, cur_nxt;
  logic signed [SAMPLE_W-1:0] hold_r, hold_nxt;
  logic signed [WEIGHT_W-1:0] wnew_r, wnew_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [E_W-1:0]      err_r, err_nxt;
  logic                       neg_r, neg_nxt;
  logic [MAG_W-1:0]           mag_r, mag_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [SUM_W:0]             rnd_r, rnd_nxt;

  // Per-channel history pointer and error factor. Indexing uses the channel
  // bit as a select so that a single-channel build needs no index bits.
  logic [TI_W-1:0]            ptr_r [CHANNELS];
  logic [TI_W-1:0]            ptr_nxt [CHANNELS];
  logic signed [WEIGHT_W-1:0] ef_r [CHANNELS];
  logic signed [WEIGHT_W-1:0] ef_nxt [CHANNELS];

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_channel_r, out_channel_nxt;
  logic                       out_sat_r, out_sat_nxt;

  // Memory ports.
  logic                w_we, h_we;
  logic [AW-1:0]       w_waddr, h_waddr, w_raddr, h_raddr;
  logic [WEIGHT_W-1:0] w_wdata, w_rdata;
  logic [SAMPLE_W-1:0] h_wdata, h_rdata;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0]           mul_a;
  logic signed [MUL_B_W-1:0]           mul_b;
  logic signed [MUL_A_W+MUL_B_W-1:0]   mul_p;

  assign mul_p = mul_a * mul_b;

  // Combinational helpers.
  logic                       ch_ok;
  logic [AW-1:0]              in_base;
  logic [TI_W-1:0]            ptr_cur;
  logic signed [WEIGHT_W-1:0] ef_cur;
  logic [TI_W:0]              slot_sum;
  logic [TI_W:0]              slot;
  logic signed [PROD_W:0]     wsum;
  logic signed [WEIGHT_W-1:0] wsat;
  logic [E_W-1:0]             mag_abs;
  logic [SUM_W:0]             q_full;
  logic [SUM_W:0]             q_lim;
  logic [WEIGHT_W-1:0]        q_mag;
  logic signed [WEIGHT_W-1:0] ef_new;

  assign ch_ok   = (CHANNELS > 1) || !in_channel;
  assign in_base = in_channel ? AW'(TAPS) : '0;
  assign ptr_cur = ch_r ? ptr_r[CHANNELS-1] : ptr_r[0];
  assign ef_cur  = ch_r ? ef_r[CHANNELS-1] : ef_r[0];

  // History entry i (0 is the previous sample) lives in slot (ptr + i) mod TAPS.
  always_comb begin
    slot_sum = {1'b0, ptr_cur} + (TI_W + 1)'(cnt_r[TI_W-1:0]);
    if (slot_sum >= (TI_W + 1)'(TAPS)) begin
      slot = slot_sum - (TI_W + 1)'(TAPS);
    end else begin
      slot = slot_sum;
    end
  end

  assign h_raddr = base_r + AW'(slot[TI_W-1:0]);
  assign w_raddr = base_r + AW'(cnt_r[TI_W-1:0]);

  // Weight plus error term, saturated to 32 bits: it fits when all bits from
  // the weight's sign bit upward agree.
  always_comb begin
    wsum = (PROD_W + 1)'($signed(w_rdata)) + (PROD_W + 1)'(prod_r);
    if ((&wsum[PROD_W:WEIGHT_W-1]) || !(|wsum[PROD_W:WEIGHT_W-1])) begin
      wsat = wsum[WEIGHT_W-1:0];
    end else if (wsum[PROD_W]) begin
      wsat = 32'sh8000_0000;
    end else begin
      wsat = 32'sh7fff_ffff;
    end
  end

  assign mag_abs = err_r[E_W-1] ? (~err_r + E_W'(1)) : err_r;

  // Error factor: rounded magnitude scaled down, clamped, then signed.
  always_comb begin
    q_full = rnd_r >> STEP_FRAC_BITS;
    q_lim  = neg_r ? LIM_NEG : LIM_POS;
    if (q_full > q_lim) begin
      q_mag = q_lim[WEIGHT_W-1:0];
    end else begin
      q_mag = q_full[WEIGHT_W-1:0];
    end
    ef_new = neg_r ? -$signed(q_mag) : $signed(q_mag);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    ch_nxt          = ch_r;
    base_nxt        = base_r;
    x_nxt           = x_r;
    ref_nxt         = ref_r;
    cur_nxt         = cur_r;
    hold_nxt        = hold_r;
    wnew_nxt        = wnew_r;
    prod_nxt        = prod_r;
    acc_nxt         = acc_r;
    err_nxt         = err_r;
    neg_nxt         = neg_r;
    mag_nxt         = mag_r;
    sum_nxt         = sum_r;
    rnd_nxt         = rnd_r;
    ptr_nxt         = ptr_r;
    ef_nxt          = ef_r;
    out_sample_nxt  = out_sample_r;
    out_channel_nxt = out_channel_r;
    out_sat_nxt     = out_sat_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    mul_a   = '0;
    mul_b   = '0;
    w_we    = 1'b0;
    w_waddr = w_raddr;
    w_wdata = '0;
    h_we    = 1'b0;
    h_waddr = h_raddr;
    h_wdata = '0;

    unique case (state_r)
      ST_INIT: begin
        w_we    = 1'b1;
        w_waddr = AW'(cnt_r);
        h_we    = 1'b1;
        h_waddr = AW'(cnt_r);
        if (cnt_r == CW'(DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid && ch_ok) begin
          unique case (in_command)
            CMD_FILTER: begin
              ch_nxt    = in_channel;
              base_nxt  = in_base;
              x_nxt     = in_sample;
              ref_nxt   = in_reference;
              cur_nxt   = in_sample;
              acc_nxt   = '0;
              prod_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = ST_RD;
            end
            CMD_LOAD: begin
              if (32'(in_weight_index) < 32'(TAPS)) begin
                w_we    = 1'b1;
                w_waddr = in_base + AW'(in_weight_index);
                w_wdata = in_weight_value;
              end
            end
            CMD_CLEAR: begin
              if (in_channel) begin
                ef_nxt[CHANNELS-1] = '0;
              end else begin
                ef_nxt[0] = '0;
              end
              ch_nxt    = in_channel;
              base_nxt  = in_base;
              cnt_nxt   = '0;
              state_nxt = ST_CLR;
            end
            default: ;
          endcase
        end
      end

      ST_CLR: begin
        h_we    = 1'b1;
        h_waddr = base_r + AW'(cnt_r[TI_W-1:0]);
        if (cnt_r == CW'(TAPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      ST_RD: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        state_nxt = ST_MW;
      end

      ST_MW: begin
        mul_a     = MUL_A_W'(ef_cur);
        mul_b     = MUL_B_W'($signed(h_rdata));
        prod_nxt  = mul_p[PROD_W-1:0];
        hold_nxt  = h_rdata;
        state_nxt = ST_UP;
      end

      ST_UP: begin
        if (adapt_r) begin
          wnew_nxt = wsat;
          w_we     = 1'b1;
          w_wdata  = wsat;
        end else begin
          wnew_nxt = w_rdata;
        end
        state_nxt = ST_MX;
      end

      ST_MX: begin
        mul_a    = MUL_A_W'(wnew_r);
        mul_b    = MUL_B_W'(cur_r);
        prod_nxt = mul_p[PROD_W-1:0];
        cur_nxt  = hold_r;
        if (cnt_r + CW'(1) == CW'(eff_taps)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_RD;
        end
      end

      ST_FIN: begin
        acc_nxt = acc_r + ACC_W'(prod_r);
        // Pushing the new sample moves the pointer back by one slot; the
        // oldest entry is overwritten.
        if (ch_r) begin
          ptr_nxt[CHANNELS-1] = (ptr_cur == '0) ? TI_W'(TAPS - 1) : ptr_cur - TI_W'(1);
          h_waddr = base_r + AW'(ptr_nxt[CHANNELS-1]);
        end else begin
          ptr_nxt[0] = (ptr_cur == '0) ? TI_W'(TAPS - 1) : ptr_cur - TI_W'(1);
          h_waddr = base_r + AW'(ptr_nxt[0]);
        end
        h_we      = 1'b1;
        h_wdata   = x_r;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_channel_nxt = ch_r;
          if (acc_r > OUT_HI) begin
            out_sample_nxt = S16_MAX;
            out_sat_nxt    = 1'b1;
          end else if (acc_r < OUT_LO) begin
            out_sample_nxt = S16_MIN;
            out_sat_nxt    = 1'b1;
          end else begin
            out_sample_nxt = SAMPLE_W'(acc_r >>> WEIGHT_FRAC_BITS);
            out_sat_nxt    = 1'b0;
          end
          state_nxt = adapt_r ? ST_ESUB : ST_IDLE;
        end
      end

      ST_ESUB: begin
        err_nxt   = (E_W'(ref_r) <<< WEIGHT_FRAC_BITS) - E_W'(acc_r);
        state_nxt = ST_EABS;
      end

      ST_EABS: begin
        neg_nxt   = err_r[E_W-1];
        mag_nxt   = MAG_W'(mag_abs);
        cnt_nxt   = '0;
        state_nxt = ST_EMUL;
      end

      ST_EMUL: begin
        // Most significant digit first: each cycle multiplies one digit and
        // folds the previous partial product into the running sum.
        if (cnt_r != CW'(NDIG)) begin
          mul_a    = {1'b0, step_r};
          mul_b    = {1'b0, mag_r[MAG_W-1 -: DIG_W]};
          prod_nxt = mul_p[PROD_W-1:0];
          mag_nxt  = mag_r << DIG_W;
        end
        if (cnt_r == '0) begin
          sum_nxt = '0;
        end else begin
          sum_nxt = (sum_r << DIG_W) + SUM_W'(prod_r[STEP_W+DIG_W-1:0]);
        end
        if (cnt_r == CW'(NDIG)) begin
          cnt_nxt   = '0;
          state_nxt = ST_RND;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      ST_RND: begin
        rnd_nxt   = (SUM_W + 1)'(sum_r) + RND_HALF;
        state_nxt = ST_ESAT;
      end

      ST_ESAT: begin
        if (ch_r) begin
          ef_nxt[CHANNELS-1] = ef_new;
        end else begin
          ef_nxt[0] = ef_new;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_r[c] <= '0;
        ef_r[c]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      ef_r        <= ef_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ch_r          <= ch_nxt;
    base_r        <= base_nxt;
    x_r           <= x_nxt;
    ref_r         <= ref_nxt;
    cur_r         <= cur_nxt;
    hold_r        <= hold_nxt;
    wnew_r        <= wnew_nxt;
    prod_r        <= prod_nxt;
    acc_r         <= acc_nxt;
    err_r         <= err_nxt;
    neg_r         <= neg_nxt;
    mag_r         <= mag_nxt;
    sum_r         <= sum_nxt;
    rnd_r         <= rnd_nxt;
    out_sample_r  <= out_sample_nxt;
    out_channel_r <= out_channel_nxt;
    out_sat_r     <= out_sat_nxt;
  end

  // ---------------------------------------------------------------------------
  // Weight and history banks
  // ---------------------------------------------------------------------------
  lmsf_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WEIGHT_W)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (w_we),
    .wr_addr (w_waddr),
    .wr_data (w_wdata),
    .rd_addr (w_raddr),
    .rd_data (w_rdata)
  );

  lmsf_ram #(
    .DEPTH (DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_history_ram (
    .clk     (clk),
    .wr_en   (h_we),
    .wr_addr (h_waddr),
    .wr_data (h_wdata),
    .rd_addr (h_raddr),
    .rd_data (h_rdata)
  );

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_channel   = out_channel_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lmsf_checker.sv =====
// Port-level checks for the LMS adaptive FIR unit, bound to the top level.
// Depends on lmsf_pkg for the command codes.
`default_nettype none

module lmsf_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [lmsf_pkg::CMD_W-1:0]           in_command,
  input logic                                 in_channel,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [lmsf_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                 out_channel,
  input logic                                 out_saturated
);

  import lmsf_pkg::*;

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample)
      && $stable(out_channel) && $stable(out_saturated))
    else $error("result changed while stalled");

  // A clamped result sits at one of the two 16-bit limits.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_sample == S16_MAX || out_sample == S16_MIN)
    else $error("saturated flag without a limit value");

  // A filter request on channel 0 occupies the unit.
  a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_FILTER && !in_channel |=> !in_ready)
    else $error("ready high straight after a filter request");

  // A weight load completes in the cycle it is taken.
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_LOAD |=> in_ready)
    else $error("weight load stalled the unit");

  // New results only appear while the unit is busy with a filter request.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind lms_adaptive_fir_unit lmsf_checker u_lmsf_checker (.*);

`default_nettype wire
